// ===== rtl/brp_pkg.sv =====
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types, codes and helpers for the HTTP byte-range parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brp_pkg;

  // Width of a parsed decimal number (values above 2^NUM_W-1 overflow)
  localparam int NUM_W = 63;
  // Width of offsets and of the resource size
  localparam int OFS_W = 63;
  // Result queue depth and its pointer / count widths
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_MULTI     = 2'd2;
  localparam logic [1:0] ST_UNSAT     = 2'd3;

  // Parse phase codes
  localparam logic [2:0] PH_UNIT   = 3'd0;
  localparam logic [2:0] PH_F_LEAD = 3'd1;
  localparam logic [2:0] PH_F_SIGN = 3'd2;
  localparam logic [2:0] PH_F_DIG  = 3'd3;
  localparam logic [2:0] PH_L_LEAD = 3'd4;
  localparam logic [2:0] PH_L_SIGN = 3'd5;
  localparam logic [2:0] PH_L_DIG  = 3'd6;

  // Offsets of the sub-phases from a number's lead phase
  localparam logic [2:0] SUB_LEAD = 3'd0;
  localparam logic [2:0] SUB_SIGN = 3'd1;
  localparam logic [2:0] SUB_DIG  = 3'd2;

  // Number of letters in the unit token
  localparam logic [2:0] UNIT_LEN = 3'd5;

  // Characters
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // Input word
  typedef struct packed {
    logic [7:0] header_byte;
    logic       end_of_value;
  } in_t;

  // Result word
  typedef struct packed {
    logic [1:0]       range_status;
    logic [OFS_W-1:0] first_offset;
    logic [OFS_W-1:0] last_offset;
  } out_t;

  // Parse state captured at the end-of-value byte
  typedef struct packed {
    logic             bad_prefix;
    logic             comma;
    logic             dash_one;
    logic             start_present;
    logic             start_bad;
    logic             end_present;
    logic             end_bad;
    logic [NUM_W-1:0] start_value;
    logic [NUM_W-1:0] end_value;
  } snap_t;

  // Letters of the unit token, lower case
  function automatic logic [7:0] unit_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h62; // b
      3'd1:    ch = 8'h79; // y
      3'd2:    ch = 8'h74; // t
      3'd3:    ch = 8'h65; // e
      3'd4:    ch = 8'h73; // s
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== rtl/brp_parse.sv =====
// ----------------------------------------------------------------------------
// brp_parse
// Per-byte parser: unit check, dash/comma tracking and the two decimal
// accumulators. Captures the parse state at the end-of-value byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brp_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_v,
  input  brp_pkg::in_t   byte_in,
  output logic           snap_v,
  output brp_pkg::snap_t snap
);
  import brp_pkg::*;

  localparam int PW = NUM_W + 4;

  logic [2:0]       phase_r, phase_nxt;
  logic [2:0]       umc_r, umc_nxt;
  logic             prefix_bad_r, prefix_bad_nxt;
  logic             comma_r, comma_nxt;
  logic [1:0]       dash_r, dash_nxt;
  logic             gap_r, gap_nxt;
  logic [NUM_W-1:0] sv_r, sv_nxt;
  logic             sp_r, sp_nxt;
  logic             sb_r, sb_nxt;
  logic [NUM_W-1:0] ev_r, ev_nxt;
  logic             ep_r, ep_nxt;
  logic             eb_r, eb_nxt;
  logic             snap_v_r;
  snap_t            snap_r, snap_nxt;

  logic [7:0]       c;
  logic [7:0]       lc;
  logic [2:0]       base;
  logic [2:0]       sub;
  logic [NUM_W-1:0] cur_val;
  logic             cur_pres;
  logic             cur_bad;
  logic [PW-1:0]    prod;
  logic             is_digit;

  assign c        = byte_in.header_byte;
  assign lc       = ((c >= CH_UA) && (c <= CH_UZ)) ? (c | 8'h20) : c;
  assign is_digit = (c >= CH_0) && (c <= CH_9);
  assign base     = (dash_r == 2'd0) ? PH_F_LEAD : PH_L_LEAD;
  assign sub      = phase_r - base;
  assign cur_val  = (dash_r == 2'd0) ? sv_r : ev_r;
  // value*10 + digit, top bits flag an overflow
  assign prod     = (PW'(cur_val) << 3) + (PW'(cur_val) << 1) + PW'(c - CH_0);

  // Next parse state for one byte
  always_comb begin
    phase_nxt      = phase_r;
    umc_nxt        = umc_r;
    prefix_bad_nxt = prefix_bad_r;
    comma_nxt      = comma_r;
    dash_nxt       = dash_r;
    gap_nxt        = gap_r;
    sv_nxt         = sv_r;
    sp_nxt         = sp_r;
    sb_nxt         = sb_r;
    ev_nxt         = ev_r;
    ep_nxt         = ep_r;
    eb_nxt         = eb_r;
    cur_pres       = (dash_r == 2'd0) ? sp_r : ep_r;
    cur_bad        = (dash_r == 2'd0) ? sb_r : eb_r;

    if (phase_r == PH_UNIT) begin
      if (c == CH_EQ) begin
        if (umc_r != UNIT_LEN) prefix_bad_nxt = 1'b1;
        phase_nxt = PH_F_LEAD;
        gap_nxt   = 1'b0;
      end else if (is_ws(c)) begin
        if (umc_r != 3'd0) gap_nxt = 1'b1;
      end else if (gap_r || (umc_r >= UNIT_LEN) || (lc != unit_char(umc_r))) begin
        prefix_bad_nxt = 1'b1;
      end else begin
        umc_nxt = umc_r + 3'd1;
      end
    end else if (c == CH_DASH) begin
      if (dash_r == 2'd0) begin
        if (phase_r == PH_F_SIGN) sb_nxt = 1'b1;
        phase_nxt = PH_L_LEAD;
        gap_nxt   = 1'b0;
      end
      if (dash_r != 2'd2) dash_nxt = dash_r + 2'd1;
    end else begin
      if (c == CH_COMMA) comma_nxt = 1'b1;
      if (dash_r != 2'd2) begin
        // one character of the current number field
        if (is_ws(c)) begin
          if (sub != SUB_LEAD) gap_nxt = 1'b1;
        end else begin
          cur_pres = 1'b1;
          if (gap_r) begin
            cur_bad = 1'b1;
          end else if ((sub == SUB_LEAD) && (c == CH_PLUS)) begin
            phase_nxt = base + SUB_SIGN;
          end else if (is_digit) begin
            phase_nxt = base + SUB_DIG;
            if (!cur_bad) begin
              if (prod[PW-1:NUM_W] != '0) begin
                cur_bad = 1'b1;
              end else if (dash_r == 2'd0) begin
                sv_nxt = prod[NUM_W-1:0];
              end else begin
                ev_nxt = prod[NUM_W-1:0];
              end
            end
          end else begin
            cur_bad = 1'b1;
          end
        end
        if (dash_r == 2'd0) begin
          sp_nxt = cur_pres;
          sb_nxt = cur_bad;
        end else begin
          ep_nxt = cur_pres;
          eb_nxt = cur_bad;
        end
      end
    end
  end

  // End-of-value snapshot; a dangling sign marks its number bad
  always_comb begin
    snap_nxt.bad_prefix    = (phase_nxt == PH_UNIT) || prefix_bad_nxt;
    snap_nxt.comma         = comma_nxt;
    snap_nxt.dash_one      = (dash_nxt == 2'd1);
    snap_nxt.start_present = sp_nxt;
    snap_nxt.start_bad     = sb_nxt || (phase_nxt == PH_F_SIGN);
    snap_nxt.end_present   = ep_nxt;
    snap_nxt.end_bad       = eb_nxt || (phase_nxt == PH_L_SIGN);
    snap_nxt.start_value   = sv_nxt;
    snap_nxt.end_value     = ev_nxt;
  end

  // Parse state registers; cleared after the last byte of a value
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_v && byte_in.end_of_value)) begin
      phase_r      <= PH_UNIT;
      umc_r        <= '0;
      prefix_bad_r <= 1'b0;
      comma_r      <= 1'b0;
      dash_r       <= '0;
      gap_r        <= 1'b0;
      sv_r         <= '0;
      sp_r         <= 1'b0;
      sb_r         <= 1'b0;
      ev_r         <= '0;
      ep_r         <= 1'b0;
      eb_r         <= 1'b0;
    end else if (byte_v) begin
      phase_r      <= phase_nxt;
      umc_r        <= umc_nxt;
      prefix_bad_r <= prefix_bad_nxt;
      comma_r      <= comma_nxt;
      dash_r       <= dash_nxt;
      gap_r        <= gap_nxt;
      sv_r         <= sv_nxt;
      sp_r         <= sp_nxt;
      sb_r         <= sb_nxt;
      ev_r         <= ev_nxt;
      ep_r         <= ep_nxt;
      eb_r         <= eb_nxt;
    end
  end

  // Snapshot register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= byte_v && byte_in.end_of_value;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_v && byte_in.end_of_value) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_v = snap_v_r;
  assign snap   = snap_r;

endmodule

// ===== rtl/brp_eval.sv =====
// ----------------------------------------------------------------------------
// brp_eval
// Range evaluation: one stage of compares against the resource size, then
// status priority and offset selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brp_eval (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [brp_pkg::OFS_W-1:0] cfg_wdata,
  input  logic                      snap_v,
  input  brp_pkg::snap_t            snap,
  output logic                      cmp_v,
  output logic                      res_v,
  output brp_pkg::out_t             res
);
  import brp_pkg::*;

  logic [OFS_W-1:0] size_r;
  logic [OFS_W-1:0] size_m1_r;

  logic [OFS_W-1:0] sv;
  logic [OFS_W-1:0] ev;

  logic             a_v_r;
  snap_t            a_snap_r;
  logic             size_zero_r;
  logic             ev_zero_r;
  logic             ev_lt_size_r;
  logic             sv_ge_size_r;
  logic             ev_lt_sv_r;
  logic             ev_lt_szm1_r;
  logic [OFS_W-1:0] tail_first_r;
  logic [OFS_W-1:0] sv_r;
  logic [OFS_W-1:0] ev_r;

  assign sv = OFS_W'(snap.start_value);
  assign ev = OFS_W'(snap.end_value);

  // Resource size, with size-1 kept alongside for the clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= '0;
      size_m1_r <= '1;
    end else if (cfg_we) begin
      size_r    <= cfg_wdata;
      size_m1_r <= cfg_wdata - OFS_W'(1);
    end
  end

  // Compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= snap_v;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_v) begin
      a_snap_r     <= snap;
      size_zero_r  <= (size_r == '0);
      ev_zero_r    <= (ev == '0);
      ev_lt_size_r <= (ev < size_r);
      sv_ge_size_r <= (sv >= size_r);
      ev_lt_sv_r   <= (ev < sv);
      ev_lt_szm1_r <= (ev < size_m1_r);
      tail_first_r <= size_r - ev;
      sv_r         <= sv;
      ev_r         <= ev;
    end
  end

  // Status priority and offsets
  always_comb begin
    res.range_status = ST_OK;
    res.first_offset = '0;
    res.last_offset  = '0;
    if (a_snap_r.bad_prefix) begin
      res.range_status = ST_MALFORMED;
    end else if (a_snap_r.comma) begin
      res.range_status = ST_MULTI;
    end else if (!a_snap_r.dash_one) begin
      res.range_status = ST_MALFORMED;
    end else if (!a_snap_r.start_present && !a_snap_r.end_present) begin
      res.range_status = ST_MALFORMED;
    end else if (size_zero_r) begin
      res.range_status = ST_UNSAT;
    end else if (!a_snap_r.start_present) begin
      // suffix form: last min(suffix, size) bytes
      if (a_snap_r.end_bad) begin
        res.range_status = ST_MALFORMED;
      end else if (ev_zero_r) begin
        res.range_status = ST_UNSAT;
      end else begin
        res.first_offset = ev_lt_size_r ? tail_first_r : '0;
        res.last_offset  = size_m1_r;
      end
    end else if (a_snap_r.start_bad) begin
      res.range_status = ST_MALFORMED;
    end else if (sv_ge_size_r) begin
      res.range_status = ST_UNSAT;
    end else if (!a_snap_r.end_present) begin
      res.first_offset = sv_r;
      res.last_offset  = size_m1_r;
    end else if (a_snap_r.end_bad) begin
      res.range_status = ST_MALFORMED;
    end else if (ev_lt_sv_r) begin
      res.range_status = ST_UNSAT;
    end else begin
      res.first_offset = sv_r;
      res.last_offset  = ev_lt_szm1_r ? ev_r : size_m1_r;
    end
  end

  assign cmp_v = a_v_r;
  assign res_v = a_v_r;

endmodule

// ===== rtl/brp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// brp_out_fifo
// Result queue in front of the output channel; its head is the output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brp_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  brp_pkg::out_t              push_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output brp_pkg::out_t              out_data,
  output logic [brp_pkg::QCNT_W-1:0] count
);
  import brp_pkg::*;

  out_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign count     = count_r;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/http_byte_range_parser.sv =====
// ----------------------------------------------------------------------------
// http_byte_range_parser
// Parses one HTTP Range header value ("bytes=first-last", "bytes=first-",
// "bytes=-suffix") one byte per word and reports status and clamped offsets.
// ----------------------------------------------------------------------------
// The block takes one header byte per cycle while in_ready is high, and
// gives one result word for each byte marked end_of_value. The input
// register loads at the accepting edge, then the parse snapshot register,
// the compare register (against the resource size) and, through the status
// select, the result queue load in turn. Results wait in an 8-deep queue;
// in_ready drops only when the queued results plus those still in the
// pipeline reach eight, so with out_ready held high the input never stalls.
// The user must write resource_size through cfg_we / cfg_wdata only while
// no value is in progress; the block itself does not enforce this.
`timescale 1ns / 1ps

module http_byte_range_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  brp_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output brp_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [brp_pkg::OFS_W-1:0] cfg_wdata
);
  import brp_pkg::*;

  logic              s0_v_r;
  in_t               s0_r;
  logic              snap_v;
  snap_t             snap;
  logic              cmp_v;
  logic              res_v;
  out_t              res;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   pending;
  logic              in_accept;

  // Credit check: results queued plus results in flight
  assign pending   = (QCNT_W + 1)'(q_count)
                   + (QCNT_W + 1)'(s0_v_r && s0_r.end_of_value)
                   + (QCNT_W + 1)'(snap_v)
                   + (QCNT_W + 1)'(cmp_v);
  assign in_ready  = (pending < (QCNT_W + 1)'(QDEPTH));
  assign in_accept = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_r <= in_data;
    end
  end

  brp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_v  (s0_v_r),
    .byte_in (s0_r),
    .snap_v  (snap_v),
    .snap    (snap)
  );

  brp_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .snap_v    (snap_v),
    .snap      (snap),
    .cmp_v     (cmp_v),
    .res_v     (res_v),
    .res       (res)
  );

  brp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

endmodule

// ===== test/http_byte_range_parser_tb.sv =====
// ----------------------------------------------------------------------------
// http_byte_range_parser_tb
// Self-checking bench for the HTTP byte-range parser. A table of header
// values covers the corner cases first, then random values (mostly
// well-formed ranges with random numbers, some mutated, some noise) run under
// several resource sizes and flow-control mixes. Each result word is checked
// field by field against a table entry or a behavioral parser in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_byte_range_parser_tb;
  import brp_pkg::*;

  localparam int PIPE_LAT = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_BYTES_PER_PHASE = 150;
  localparam int N_PHASES = 8;
  localparam int N_DIR = 26;
  localparam logic [OFS_W-1:0] SIZE_MAX = {OFS_W{1'b1}};
  localparam logic [63:0] NUM_LIMIT = (64'd1 << NUM_W) - 64'd1;
  localparam logic [39:0] UNIT_WORD = "bytes";

  // DUT ports
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [OFS_W-1:0] cfg_wdata = '0;

  http_byte_range_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Flow-control mix, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Checker state
  out_t expected_ranges [$];
  out_t want_range;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // Parser model state
  logic [OFS_W-1:0] size_reg = '0;
  logic [2:0]       phase = PH_UNIT;
  logic [2:0]       unit_cnt = '0;
  logic             prefix_err = 1'b0;
  logic             saw_comma = 1'b0;
  logic [1:0]       dashes = '0;
  logic             gap = 1'b0;
  logic [NUM_W-1:0] first_num = '0;
  logic             first_seen = 1'b0;
  logic             first_err = 1'b0;
  logic [NUM_W-1:0] last_num = '0;
  logic             last_seen = 1'b0;
  logic             last_err = 1'b0;

  // Bytes of the header value about to be sent
  logic [7:0] hdr_bytes [$];
  int         phase_bytes;

  // Directed values. '#' stands for a NUL byte and '~' for 0xFF.
  typedef struct packed {
    logic check_typed;
    out_t res;
  } dir_exp_t;

  string dir_text [N_DIR] = '{
    "bytes=0-9", "bytes=0-9", "BYTES=10-", "bytes=-30",
    " \tBytes \015= \n+5 - +7\013\014", "bytes=0-1,2-3", "bytes=1-2-3", "bytes=5",
    "bytes=-", "byte=0-1", "bytes 0-1", "b ytes=0-1",
    "bytes=-0", "bytes=-500", "bytes=100-", "bytes=50-10",
    "bytes=+5-+500", "bytes=+-5", "bytes=1-+", "bytes=1 2-3",
    "bytes=#-~", "=", "bytes=0-9223372036854775807", "bytes=9223372036854775806-",
    "bytes=-9223372036854775808", "bytes=0-0"
  };

  logic [OFS_W-1:0] dir_size [N_DIR] = '{
    63'd0, 63'd100, 63'd100, 63'd100, 63'd100, 63'd100, 63'd100, 63'd100,
    63'd100, 63'd100, 63'd100, 63'd100, 63'd100, 63'd100, 63'd100, 63'd100,
    63'd100, 63'd100, 63'd100, 63'd100, 63'd100, 63'd100, SIZE_MAX, SIZE_MAX,
    SIZE_MAX, 63'd1
  };

  dir_exp_t dir_exp [N_DIR] = '{
    '{1'b1, '{ST_UNSAT, 63'd0, 63'd0}},
    '{1'b1, '{ST_OK, 63'd0, 63'd9}},
    '{1'b1, '{ST_OK, 63'd10, 63'd99}},
    '{1'b1, '{ST_OK, 63'd70, 63'd99}},
    '{1'b0, '{ST_OK, 63'd0, 63'd0}},
    '{1'b1, '{ST_MULTI, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_UNSAT, 63'd0, 63'd0}},
    '{1'b1, '{ST_OK, 63'd0, 63'd99}},
    '{1'b1, '{ST_UNSAT, 63'd0, 63'd0}},
    '{1'b1, '{ST_UNSAT, 63'd0, 63'd0}},
    '{1'b0, '{ST_OK, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_OK, 63'd0, 63'd9223372036854775806}},
    '{1'b0, '{ST_OK, 63'd0, 63'd0}},
    '{1'b1, '{ST_MALFORMED, 63'd0, 63'd0}},
    '{1'b1, '{ST_OK, 63'd0, 63'd0}}
  };

  function automatic logic space_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // One character of the first (second = 0) or last (second = 1) number
  task automatic number_step(input logic [7:0] c, input logic second);
    logic [2:0]       base;
    logic [2:0]       sub;
    logic [NUM_W-1:0] val;
    logic             seen;
    logic             err;
    logic [63:0]      digit;
    base = second ? PH_L_LEAD : PH_F_LEAD;
    sub  = phase - base;
    val  = second ? last_num : first_num;
    seen = second ? last_seen : first_seen;
    err  = second ? last_err : first_err;
    if (space_char(c)) begin
      if (sub != SUB_LEAD) gap = 1'b1;
    end else begin
      seen = 1'b1;
      if (gap) begin
        err = 1'b1;
      end else if (sub == SUB_LEAD && c == CH_PLUS) begin
        phase = base + SUB_SIGN;
      end else if (c >= CH_0 && c <= CH_9) begin
        digit = {56'd0, c - CH_0};
        phase = base + SUB_DIG;
        if (!err) begin
          // overflow once the value would pass 2^NUM_W-1
          if ({1'b0, val} > (NUM_LIMIT - digit) / 64'd10) err = 1'b1;
          else val = NUM_W'({1'b0, val} * 64'd10 + digit);
        end
      end else begin
        err = 1'b1;
      end
    end
    if (second) begin
      last_num = val; last_seen = seen; last_err = err;
    end else begin
      first_num = val; first_seen = seen; first_err = err;
    end
  endtask

  // Status and clamped offsets at the end of a value
  function automatic out_t resolve_range();
    out_t             r;
    logic [OFS_W-1:0] span;
    r = '0;
    r.range_status = ST_OK;
    if (phase == PH_F_SIGN) first_err = 1'b1;
    if (phase == PH_L_SIGN) last_err = 1'b1;
    if (phase == PH_UNIT || prefix_err) r.range_status = ST_MALFORMED;
    else if (saw_comma) r.range_status = ST_MULTI;
    else if (dashes != 2'd1) r.range_status = ST_MALFORMED;
    else if (!first_seen && !last_seen) r.range_status = ST_MALFORMED;
    else if (size_reg == '0) r.range_status = ST_UNSAT;
    else if (!first_seen) begin
      // suffix form: last min(suffix, size) bytes
      if (last_err) r.range_status = ST_MALFORMED;
      else if (last_num == '0) r.range_status = ST_UNSAT;
      else begin
        span = (last_num < size_reg) ? last_num : size_reg;
        r.first_offset = size_reg - span;
        r.last_offset  = size_reg - 1'b1;
      end
    end else if (first_err) r.range_status = ST_MALFORMED;
    else if (first_num >= size_reg) r.range_status = ST_UNSAT;
    else if (!last_seen) begin
      r.first_offset = first_num;
      r.last_offset  = size_reg - 1'b1;
    end else if (last_err) r.range_status = ST_MALFORMED;
    else if (last_num < first_num) r.range_status = ST_UNSAT;
    else begin
      r.first_offset = first_num;
      r.last_offset  = (last_num < size_reg - 1'b1) ? last_num : size_reg - 1'b1;
    end
    if (r.range_status != ST_OK) begin
      r.first_offset = '0;
      r.last_offset  = '0;
    end
    return r;
  endfunction

  // Advance the parser model by one accepted word
  task automatic parse_header_byte(input in_t w, output logic has_res, output out_t res);
    logic [7:0] c;
    logic [7:0] lc;
    c = w.header_byte;
    res = '0;
    if (phase == PH_UNIT) begin
      if (c == CH_EQ) begin
        if (unit_cnt != UNIT_LEN) prefix_err = 1'b1;
        phase = PH_F_LEAD;
        gap = 1'b0;
      end else if (space_char(c)) begin
        if (unit_cnt != 3'd0) gap = 1'b1;
      end else begin
        lc = (c >= CH_UA && c <= CH_UZ) ? (c | 8'h20) : c;
        if (gap || unit_cnt >= UNIT_LEN || lc != UNIT_WORD[39 - 8*unit_cnt -: 8])
          prefix_err = 1'b1;
        else
          unit_cnt = unit_cnt + 3'd1;
      end
    end else begin
      if (c == CH_COMMA) saw_comma = 1'b1;
      if (c == CH_DASH) begin
        if (dashes == 2'd0) begin
          if (phase == PH_F_SIGN) first_err = 1'b1;
          phase = PH_L_LEAD;
          gap = 1'b0;
        end
        if (dashes != 2'd2) dashes = dashes + 2'd1;
      end else if (dashes == 2'd0) begin
        number_step(c, 1'b0);
      end else if (dashes == 2'd1) begin
        number_step(c, 1'b1);
      end
    end
    has_res = w.end_of_value;
    if (has_res) begin
      res = resolve_range();
      phase = PH_UNIT; unit_cnt = '0; prefix_err = 1'b0; saw_comma = 1'b0;
      dashes = '0; gap = 1'b0;
      first_num = '0; first_seen = 1'b0; first_err = 1'b0;
      last_num = '0; last_seen = 1'b0; last_err = 1'b0;
    end
  endtask

  // Send hdr_bytes as one value; end_of_value on the last word
  task automatic send_value(input logic use_typed, input out_t typed);
    in_t  w;
    out_t got;
    logic has_res;
    int   n;
    n = hdr_bytes.size();
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      w.header_byte  = hdr_bytes[i];
      w.end_of_value = (i == n - 1);
      in_valid <= 1'b1;
      in_data  <= w;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      parse_header_byte(w, has_res, got);
      if (has_res) expected_ranges.push_back(use_typed ? typed : got);
    end
    phase_bytes += n;
  endtask

  // Wait for all results, let the pipeline settle, then write the size
  task automatic set_resource_size(input logic [OFS_W-1:0] sz);
    in_valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg = sz;
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) hdr_bytes.push_back(t[i]);
  endtask

  // Optional whitespace run
  task automatic push_space();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < n; i++)
      hdr_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
  endtask

  // Decimal number, mostly around the current size
  task automatic push_number();
    logic [63:0] v;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      if (size_reg <= 63'd1000) v = 64'($urandom_range(0, int'(size_reg) + 3));
      else v = {$urandom, $urandom} % ({1'b0, size_reg} + 64'd1);
    end else if (pick <= 7) v = 64'($urandom_range(0, 20));
    else if (pick == 8) v = {$urandom, $urandom} >> 1;
    else v = NUM_LIMIT;
    if ($urandom_range(0, 4) == 0) hdr_bytes.push_back(CH_PLUS);
    if ($urandom_range(0, 9) == 0) hdr_bytes.push_back(CH_0);
    case ($urandom_range(0, 3))
      0:       push_text("9223372036854775808");  // one past the number limit
      1:       push_text("99999999999999999999");
      default: push_text($sformatf("%0d", v));
    endcase
  endtask

  // Build one random header value
  task automatic compose_header();
    int         kind;
    int         form;
    int         pos;
    logic [7:0] ch;
    hdr_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 90) begin
      push_space();
      for (int i = 0; i < 5; i++) begin
        ch = UNIT_WORD[39 - 8*i -: 8];
        if ($urandom_range(0, 1) != 0) ch = ch ^ 8'h20;
        hdr_bytes.push_back(ch);
      end
      push_space();
      hdr_bytes.push_back(CH_EQ);
      push_space();
      form = $urandom_range(0, 2);
      if (form != 2) push_number();
      push_space();
      hdr_bytes.push_back(CH_DASH);
      push_space();
      if (form != 1) push_number();
      push_space();
      // broken sequences: one edit somewhere in the value
      if (kind >= 65) begin
        pos = $urandom_range(0, hdr_bytes.size() - 1);
        case ($urandom_range(0, 3))
          0: hdr_bytes.insert(pos, CH_COMMA);
          1: hdr_bytes.insert(pos, CH_DASH);
          2: hdr_bytes[pos] = 8'($urandom_range(0, 255));
          default: if (hdr_bytes.size() > 1) hdr_bytes.delete(pos);
        endcase
      end
    end else if (kind < 95) begin
      form = $urandom_range(1, 12);
      for (int i = 0; i < form; i++) begin
        case ($urandom_range(0, 7))
          0: ch = CH_DASH;
          1: ch = CH_COMMA;
          2: ch = CH_EQ;
          3: ch = CH_PLUS;
          4: ch = CH_SPACE;
          5: ch = UNIT_WORD[39 - 8*$urandom_range(0, 4) -: 8];
          default: ch = 8'($urandom_range(48, 57));
        endcase
        hdr_bytes.push_back(ch);
      end
    end else begin
      form = $urandom_range(1, 8);
      for (int i = 0; i < form; i++) hdr_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: check accepted words, then pick out_ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_ranges.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %0d first %0d last %0d",
                   out_data.range_status, out_data.first_offset, out_data.last_offset);
      end else begin
        want_range = expected_ranges.pop_front();
        if (out_data.range_status !== want_range.range_status ||
            out_data.first_offset !== want_range.first_offset ||
            out_data.last_offset !== want_range.last_offset) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("range mismatch: want status %0d first %0d last %0d, got %0d %0d %0d",
                     want_range.range_status, want_range.first_offset,
                     want_range.last_offset, out_data.range_status,
                     out_data.first_offset, out_data.last_offset);
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("http_byte_range_parser verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [OFS_W-1:0] phase_size;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed values; the first one runs with the reset size of zero
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_size[i] != size_reg) set_resource_size(dir_size[i]);
      hdr_bytes.delete();
      for (int k = 0; k < dir_text[i].len(); k++) begin
        if (dir_text[i][k] == "#") hdr_bytes.push_back(8'h00);
        else if (dir_text[i][k] == "~") hdr_bytes.push_back(8'hff);
        else hdr_bytes.push_back(dir_text[i][k]);
      end
      send_value(dir_exp[i].check_typed, dir_exp[i].res);
    end

    // Random values: each phase drains, sets a new size and a new flow mix
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (p)
        0: phase_size = 63'd100;
        1: phase_size = 63'd0;
        2: phase_size = SIZE_MAX;
        3: phase_size = 63'd1;
        4: phase_size = 63'($urandom_range(2, 1000));
        5: phase_size = 63'({$urandom, $urandom} >> 1);
        6: phase_size = 63'd4294967296;
        default: phase_size = 63'($urandom_range(1, 50));
      endcase
      set_resource_size(phase_size);
      phase_bytes = 0;
      while (phase_bytes < RAND_BYTES_PER_PHASE) begin
        compose_header();
        send_value(1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk);
    repeat (PIPE_LAT * 4) @(posedge clk);
    if (mismatch_count == 0 && expected_ranges.size() == 0)
      $display("http_byte_range_parser verification clean");
    else
      $display("http_byte_range_parser verification failed");
    $finish;
  end

endmodule

// ===== http_byte_range_parser.f =====
rtl/brp_pkg.sv
rtl/brp_parse.sv
rtl/brp_eval.sv
rtl/brp_out_fifo.sv
rtl/http_byte_range_parser.sv
test/http_byte_range_parser_tb.sv
